### rtl/ldf_pkg.sv
`default_nettype none
package ldf_pkg;

    localparam int unsigned LenWidth      = 27;
    localparam int unsigned MaxLenDefault = 64 * 1024 * 1024;
    localparam int unsigned HdrWidth      = 24;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_ABORT   = 2'd1,
        KIND_BAD_LEN = 2'd2
    } kind_t;

    typedef enum logic {
        CMD_DATA  = 1'b0,
        CMD_RESET = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       valid;
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       last;
    } result_t;

endpackage
`default_nettype wire

### rtl/ldf_parser.sv
`default_nettype none
module ldf_parser #(
    parameter int unsigned LEN_WIDTH = ldf_pkg::LenWidth
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire logic                 cmd,
    input  wire logic [7:0]           data_byte,
    input  wire logic [LEN_WIDTH-1:0] max_packet_len,
    output ldf_pkg::result_t          result
);
    import ldf_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [HdrWidth-1:0]   header_shift_reg, header_shift_next;
    logic [1:0]            header_count_reg, header_count_next;
    logic [LEN_WIDTH-1:0]  bytes_left_reg, bytes_left_next;

    logic [31:0]           hdr_len;
    logic                  len_bad;
    logic [LEN_WIDTH-1:0]  left_dec;
    logic                  is_last;

    assign hdr_len  = {header_shift_reg, data_byte};
    assign len_bad  = (hdr_len == 32'd0) || (hdr_len > 32'(max_packet_len));
    assign left_dec = bytes_left_reg - LEN_WIDTH'(1);
    assign is_last  = (left_dec == '0);

    // next state
    always_comb begin
        phase_next        = phase_reg;
        header_shift_next = header_shift_reg;
        header_count_next = header_count_reg;
        bytes_left_next   = bytes_left_reg;
        if (cmd == CMD_RESET) begin
            phase_next        = PH_HEADER;
            header_shift_next = '0;
            header_count_next = '0;
            bytes_left_next   = '0;
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (header_count_reg != 2'd3) begin
                        header_shift_next = {header_shift_reg[HdrWidth-9:0], data_byte};
                        header_count_next = header_count_reg + 2'd1;
                    end else begin
                        header_shift_next = '0;
                        header_count_next = '0;
                        if (len_bad) begin
                            phase_next      = PH_HALTED;
                            bytes_left_next = '0;
                        end else begin
                            phase_next      = PH_PAYLOAD;
                            bytes_left_next = hdr_len[LEN_WIDTH-1:0];
                        end
                    end
                end
                PH_PAYLOAD: begin
                    bytes_left_next = left_dec;
                    if (is_last) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    // halted: drop data until link reset
                end
            endcase
        end
    end

    // result for the current word
    always_comb begin
        result              = '0;
        result.kind         = KIND_PAYLOAD;
        if (cmd == CMD_RESET) begin
            if (phase_reg == PH_PAYLOAD) begin
                result.valid = 1'b1;
                result.kind  = KIND_ABORT;
            end
        end else begin
            case (phase_reg)
                PH_HEADER: begin
                    if (header_count_reg == 2'd3 && len_bad) begin
                        result.valid = 1'b1;
                        result.kind  = KIND_BAD_LEN;
                    end
                end
                PH_PAYLOAD: begin
                    result.valid        = 1'b1;
                    result.payload_byte = data_byte;
                    result.last         = is_last;
                end
                default: begin
                    result.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_shift_reg <= '0;
            header_count_reg <= '0;
            bytes_left_reg   <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            header_shift_reg <= header_shift_next;
            header_count_reg <= header_count_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule
`default_nettype wire

### rtl/ldf_out_reg.sv
`default_nettype none
module ldf_out_reg (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              load,
    input  wire ldf_pkg::result_t  result,
    output logic                   free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);
    import ldf_pkg::*;

    logic       valid_reg, valid_next;
    kind_t      kind_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = result.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= result.kind;
            byte_reg <= result.payload_byte;
            last_reg <= result.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

### rtl/length_prefixed_deframer_top.sv
`default_nettype none
// An s_ word passes the input register, then the result register, to m_tvalid.
// Throughput: one word per cycle unless m_tready stalls; the header compare and
// the byte-count decrement sit in the single parser stage between the two registers.
// Header words (bar a bad-length last one), halted-state data and link resets
// outside a payload give no result. Reset (aresetn low, synchronous): parser to
// header phase, both stages empty, max_packet_len back to 64 MiB.
module length_prefixed_deframer_top #(
    parameter int unsigned LEN_WIDTH   = ldf_pkg::LenWidth,
    parameter int unsigned MAX_LEN_RST = ldf_pkg::MaxLenDefault
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // config write
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [LEN_WIDTH-1:0] cfg_data,    // max_packet_len
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,     // [7:0] data_byte
    input  wire logic                 s_tuser,     // [0] cmd
    // result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,     // [7:0] payload_byte
    output logic [1:0]                m_tuser,     // [1:0] kind
    output logic                      m_tlast      // last
);
    import ldf_pkg::*;

    logic [LEN_WIDTH-1:0] max_len_reg;
    logic                 in_valid_reg, in_valid_next;
    logic                 in_cmd_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_free;
    logic                 advance;
    result_t              result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= LEN_WIDTH'(MAX_LEN_RST);
        end else if (cfg_valid) begin
            max_len_reg <= cfg_data;
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    ldf_parser #(
        .LEN_WIDTH(LEN_WIDTH)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .cmd           (in_cmd_reg),
        .data_byte     (in_byte_reg),
        .max_packet_len(max_len_reg),
        .result        (result)
    );

    ldf_out_reg u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance),
        .result  (result),
        .free    (out_free),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule
`default_nettype wire
